// ===== src/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse character keyer package
// Character codes, run lengths and the Morse element tables.
// ----------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int RUN_W  = 4;
    localparam int LEN_W  = 3;
    localparam int ELEM_W = 5;

    localparam logic [CHAR_W-1:0] CHAR_EOM   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_AT    = 8'h40;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    localparam logic [RUN_W-1:0] RUN_DOT      = 4'd1;
    localparam logic [RUN_W-1:0] RUN_DASH     = 4'd3;
    localparam logic [RUN_W-1:0] RUN_ELEM_GAP = 4'd1;
    localparam logic [RUN_W-1:0] RUN_CHAR_GAP = 4'd3;
    localparam logic [RUN_W-1:0] RUN_SPACE    = 4'd4;
    localparam logic [RUN_W-1:0] RUN_EOM      = 4'd11;
    localparam logic [RUN_W-1:0] RUN_OTHER    = 4'd1;

    // Element count and element bits, first element in bit 0, a dash is 1.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ELEM_W-1:0] elems;
    } code_t;

    typedef struct packed {
        logic             load;
        logic             dec;
        logic [RUN_W-1:0] value;
    } cnt_ctrl_t;

    localparam code_t LETTER_TBL [26] = '{
        '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
        '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
        '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
        '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
        '{3'd4, 5'b01101}, '{3'd4, 5'b00011}
    };

    localparam code_t DIGIT_TBL [10] = '{
        '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
        '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
    };

endpackage

// ===== src/mck_run_counter.sv =====
// ----------------------------------------------------------------------------
// Morse character keyer run counter
// Shared down counter that times every key-on and key-off run.
// ----------------------------------------------------------------------------
module mck_run_counter
    import mck_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cnt_ctrl_t        ctrl,
    output logic             run_last
);

    logic [RUN_W-1:0] count_reg;
    logic [RUN_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = ctrl.value;
        end
        else if (ctrl.dec)
        begin
            count_next = count_reg - RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign run_last = (count_reg == RUN_W'(1));

endmodule

// ===== src/morse_character_keyer.sv =====
// ----------------------------------------------------------------------------
// Morse character keyer
// Expands one ASCII character into its Morse keying, one word per time unit.
// ----------------------------------------------------------------------------
// The slave channel takes one character per word in s_tdata. The master
// channel gives one word per time unit: m_tdata bit 0 is the key state and
// m_tlast marks the final unit of the character. Letters (either case) and
// digits follow standard timing with a three-unit trailing gap, a space gives
// four off units, code 0 gives eleven off units, '@' gives nothing and any
// other code one off unit.
// A character is accepted, then its units go out one unit per cycle while the
// receiver keeps m_tready high; '@' is accepted and sends no unit. The units
// are timed by a single down counter reloaded at each dot, dash or gap under
// a three-state sequencer.
// s_tready is high only while no character is being sent.
// When the receiver stalls, the current unit holds on the master channel and
// the sequencer waits. Reset returns the block to idle with no word pending.
// ----------------------------------------------------------------------------
module morse_character_keyer
    import mck_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] key_on, [7:1] zero
    output logic       m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_GAP
    } state_t;

    state_t            state_reg,  state_next;
    logic [LEN_W-1:0]  idx_reg,    idx_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [ELEM_W-1:0] elems_reg,  elems_next;
    logic              final_reg,  final_next;

    cnt_ctrl_t         cnt_ctrl;
    logic              run_last;

    logic [CHAR_W-1:0] upper;
    logic [CHAR_W-1:0] letter_off;
    logic [CHAR_W-1:0] digit_off;
    code_t             code;
    logic              is_code;
    logic              out_fire;
    logic              next_dash;

    mck_run_counter u_run_counter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cnt_ctrl),
        .run_last (run_last)
    );

    // Character decode: fold case, then look up letters and digits.
    always_comb
    begin
        upper = s_tdata;
        if (s_tdata >= CHAR_LA && s_tdata <= CHAR_LZ)
        begin
            upper = s_tdata - CASE_DIFF;
        end
        letter_off = upper - CHAR_UA;
        digit_off  = upper - CHAR_0;
        is_code    = 1'b1;
        code       = '0;
        if (upper >= CHAR_UA && upper <= CHAR_UZ)
        begin
            code = LETTER_TBL[letter_off[4:0]];
        end
        else if (upper >= CHAR_0 && upper <= CHAR_9)
        begin
            code = DIGIT_TBL[digit_off[3:0]];
        end
        else
        begin
            is_code = 1'b0;
        end
    end

    assign out_fire  = m_tvalid && m_tready;
    assign next_dash = elems_reg[idx_reg + LEN_W'(1)];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        elems_next     = elems_reg;
        final_next     = final_reg;
        cnt_ctrl.load  = 1'b0;
        cnt_ctrl.dec   = 1'b0;
        cnt_ctrl.value = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next   = '0;
                    len_next   = code.len;
                    elems_next = code.elems;
                    final_next = 1'b1;
                    cnt_ctrl.load = 1'b1;
                    if (is_code)
                    begin
                        state_next     = ST_MARK;
                        final_next     = 1'b0;
                        cnt_ctrl.value = code.elems[0] ? RUN_DASH : RUN_DOT;
                    end
                    else if (upper == CHAR_SPACE)
                    begin
                        state_next     = ST_GAP;
                        cnt_ctrl.value = RUN_SPACE;
                    end
                    else if (upper == CHAR_EOM)
                    begin
                        state_next     = ST_GAP;
                        cnt_ctrl.value = RUN_EOM;
                    end
                    else if (upper == CHAR_AT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next     = ST_GAP;
                        cnt_ctrl.value = RUN_OTHER;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_fire)
                begin
                    cnt_ctrl.dec = 1'b1;
                    if (run_last)
                    begin
                        state_next    = ST_GAP;
                        cnt_ctrl.load = 1'b1;
                        if (idx_reg == len_reg - LEN_W'(1))
                        begin
                            final_next     = 1'b1;
                            cnt_ctrl.value = RUN_CHAR_GAP;
                        end
                        else
                        begin
                            cnt_ctrl.value = RUN_ELEM_GAP;
                        end
                    end
                end
            end
            ST_GAP:
            begin
                if (out_fire)
                begin
                    cnt_ctrl.dec = 1'b1;
                    if (run_last)
                    begin
                        if (final_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next     = ST_MARK;
                            idx_next       = idx_reg + LEN_W'(1);
                            cnt_ctrl.load  = 1'b1;
                            cnt_ctrl.value = next_dash ? RUN_DASH : RUN_DOT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            elems_reg <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            elems_reg <= elems_next;
            final_reg <= final_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg != ST_IDLE);
    assign m_tdata  = {7'd0, (state_reg == ST_MARK)};
    assign m_tlast  = (state_reg == ST_GAP) && final_reg && run_last;

endmodule

// ===== test/keying_checker.sv =====
// ----------------------------------------------------------------------------
// Morse keying checker
// Watches both stream channels of the Morse character keyer. Each accepted
// character is expanded into its expected time units, and each word taken on
// the master channel is compared with the oldest unit still waiting.
// ----------------------------------------------------------------------------
module keying_checker
    import mck_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT_CAP    = 22;
    localparam int SHOW_LIMIT  = 10;
    localparam int DOT_UNITS   = 1;
    localparam int DASH_UNITS  = 3;
    localparam int GAP_UNITS   = 3;
    localparam int SPACE_UNITS = 4;
    localparam int EOM_UNITS   = 11;

    typedef struct packed {
        logic key_on;
        logic last_unit;
    } key_unit_t;

    key_unit_t        expected_units [$];
    logic [UNIT_CAP-1:0] keying_bits;
    int               keying_len;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic string letter_morse(input int idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    function automatic string digit_morse(input int idx);
        case (idx)
            0: return "-----";
            1: return ".----";
            2: return "..---";
            3: return "...--";
            4: return "....-";
            5: return ".....";
            6: return "-....";
            7: return "--...";
            8: return "---..";
            default: return "----.";
        endcase
    endfunction

    // Appends a run of equal units to the pattern under construction.
    function automatic void add_run(input logic on, input int n);
        for (int i = 0; i < n; i++)
        begin
            if (keying_len < UNIT_CAP)
            begin
                keying_bits[keying_len] = on;
                keying_len++;
            end
        end
    endfunction

    function automatic void add_elements(input string code);
        for (int i = 0; i < code.len(); i++)
        begin
            if (i > 0)
                add_run(1'b0, 1);
            add_run(1'b1, (code.getc(i) == "-") ? DASH_UNITS : DOT_UNITS);
        end
        add_run(1'b0, GAP_UNITS);
    endfunction

    task automatic expand_character(input logic [7:0] raw);
        logic [7:0] ch;
        key_unit_t  unit;
        ch          = raw;
        keying_bits = '0;
        keying_len  = 0;
        if (ch >= CHAR_LA && ch <= CHAR_LZ)
            ch = ch - CASE_DIFF;
        if (ch >= CHAR_UA && ch <= CHAR_UZ)
            add_elements(letter_morse(int'(ch - CHAR_UA)));
        else if (ch >= CHAR_0 && ch <= CHAR_9)
            add_elements(digit_morse(int'(ch - CHAR_0)));
        else if (ch == CHAR_SPACE)
            add_run(1'b0, SPACE_UNITS);
        else if (ch == CHAR_EOM)
            add_run(1'b0, EOM_UNITS);
        else if (ch != CHAR_AT)
            add_run(1'b0, 1);
        for (int k = 0; k < keying_len; k++)
        begin
            unit.key_on    = keying_bits[k];
            unit.last_unit = (k + 1 == keying_len);
            expected_units.push_back(unit);
        end
    endtask

    always @(posedge clk)
    begin
        key_unit_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expand_character(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_units.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t: unexpected word tdata=%h tlast=%b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (m_tdata !== {7'b0, want.key_on} || m_tlast !== want.last_unit)
                    begin
                        errors++;
                        if (errors <= SHOW_LIMIT)
                            $display("%0t: unit mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                     $time, {7'b0, want.key_on}, want.last_unit,
                                     m_tdata, m_tlast);
                    end
                end
            end
            pending = expected_units.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Morse character keyer testbench
// Sends directed characters covering every class and the table edges, then
// random text, after the first phase in bursts while the receiver stalls in
// several patterns. The keying checker predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench
    import mck_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 96;
    localparam int PHASES         = 4;
    localparam int DRAIN_CYCLES   = 30;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_LONG} ready_mode_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int          errors;
    int          pending;
    int          idle_cycles = 0;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    bit          bursty      = 1'b0;
    int          burst_left  = 0;
    int          stall_hold  = 0;
    int          tick        = 0;

    logic [7:0] directed_chars [0:24] = '{
        8'h41, 8'h7A, 8'h50, 8'h70, 8'h30, 8'h39, 8'h45, 8'h54, CHAR_SPACE,
        CHAR_EOM, CHAR_AT, 8'hFF, 8'h80, 8'h21, 8'h3F, 8'h7F, 8'h1F, 8'h2F,
        8'h3A, 8'h5B, 8'h60, 8'h7B, 8'h61, 8'h5A, 8'h51
    };

    always #5 clk = ~clk;

    morse_character_keyer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    keying_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // Receiver side: each mode gives the master channel its own m_tready rhythm.
    always @(negedge clk)
    begin
        tick <= tick + 1;
        case (ready_mode)
            RDY_ALWAYS:  m_tready <= 1'b1;
            RDY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
            RDY_PATTERN: m_tready <= ((tick % 7) < 4);
            default:
            begin
                if (stall_hold == 0)
                begin
                    m_tready   <= 1'($urandom_range(0, 1));
                    stall_hold <= $urandom_range(1, 8);
                end
                else
                    stall_hold <= stall_hold - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] pick_character();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CHAR_UA + 8'($urandom_range(0, 25));
        else if (r < 55)
            return CHAR_LA + 8'($urandom_range(0, 25));
        else if (r < 70)
            return CHAR_0 + 8'($urandom_range(0, 9));
        else if (r < 77)
            return CHAR_SPACE;
        else if (r < 82)
            return CHAR_EOM;
        else if (r < 86)
            return CHAR_AT;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // A word is held until the keyer takes it; valid stays high into the next
    // word unless the burst ends.
    task automatic send_character(input logic [7:0] ch);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 8);
            end
            else
                burst_left--;
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_chars[i])
            send_character(directed_chars[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            ready_mode = ready_mode_t'(p);
            bursty     = (p != 0);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
                send_character(pick_character());
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
